@@ design/permutation_combination_count_top_assert.svh @@
// Assertion macros for the permutation and combination counter.
// Used by permutation_combination_count_top; expects clk and rst_n in scope.
`ifndef PERMUTATION_COMBINATION_COUNT_TOP_ASSERT_SVH
`define PERMUTATION_COMBINATION_COUNT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc check failed");
`define PCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc check failed");
`else
`define PCC_ASSERT_NOW(label, ante, cons)
`define PCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/pcc_pkg.sv @@
// Shared constants and types for the permutation and combination counter.
// No dependencies; used by pcc_unit and permutation_combination_count_top.
package pcc_pkg;

    localparam int MAX_N      = 255;
    localparam int N_W        = 8;
    localparam int COUNT_W    = 31;
    localparam int PROD_W     = COUNT_W + N_W;
    localparam int RADIX_BITS = 4;
    localparam int DQ_W       = ((PROD_W + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
    localparam int DIV_STEPS  = DQ_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic CMD_PERM = 1'b0;
    localparam logic CMD_COMB = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               start;
        logic               use_div;
        logic [COUNT_W-1:0] operand;
        logic [N_W-1:0]     factor;
        logic [N_W-1:0]     divisor;
    } unit_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DQ_W-1:0] value;
    } unit_rsp_t;

endpackage

@@ design/pcc_if.sv @@
// Handshake interfaces for the request and result channels.
// Depends on pcc_pkg for field widths.
interface pcc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [pcc_pkg::N_W-1:0]    n_total;
    logic [pcc_pkg::N_W-1:0]    k_chosen;

    modport source (output valid, cmd, n_total, k_chosen, input ready);
    modport sink   (input valid, cmd, n_total, k_chosen, output ready);
endinterface

interface pcc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pcc_pkg::COUNT_W-1:0]   count;
    logic                          range_error;
    logic                          overflow;

    modport source (output valid, count, range_error, overflow, input ready);
    modport sink   (input valid, count, range_error, overflow, output ready);
endinterface

@@ design/permutation_combination_count_top.sv @@
// Top level of the permutation and combination counter: request sequencer,
// result register. Depends on pcc_pkg, pcc_if, pcc_unit and the assert header.
//
//  port  dir  word                              handshake
//  req   in   cmd, n_total, k_chosen            valid/ready
//  rsp   out  count, range_error, overflow      valid/ready
//
// Each step of the running product goes through the shared pcc_unit: a multiply
// for a permutation, a multiply and an exact radix-16 division for a
// combination. Saturation ends the loop early, so at most 16 combination steps run.
// Range errors skip the unit and go straight to the done state.
// req.ready is high when the sequencer is idle.
// A new request is taken while a result still waits on rsp.
// Reset is asynchronous, active low, and clears the sequencer state and the output valid flag.
`include "permutation_combination_count_top_assert.svh"

module permutation_combination_count_top (
    input  logic          clk,
    input  logic          rst_n,
    pcc_req_if.sink       req,
    pcc_rsp_if.source     rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic                          cmd_reg, cmd_next;
    logic [pcc_pkg::N_W-1:0]       n_reg, n_next;
    logic [pcc_pkg::N_W-1:0]       i_reg, i_next;
    logic [pcc_pkg::N_W-1:0]       kk_reg, kk_next;
    logic [pcc_pkg::COUNT_W-1:0]   r_reg, r_next;
    logic                          err_reg, err_next;
    logic                          ovf_reg, ovf_next;

    logic                          out_valid_reg, out_valid_next;
    logic [pcc_pkg::COUNT_W-1:0]   out_count_reg;
    logic                          out_err_reg;
    logic                          out_ovf_reg;
    logic                          out_load;

    logic                          in_fire;
    logic                          bad_req;
    logic [pcc_pkg::N_W-1:0]       n_minus_k;
    logic [pcc_pkg::N_W-1:0]       steps;
    logic [pcc_pkg::N_W-1:0]       i_inc;
    logic                          too_big;

    pcc_pkg::unit_req_t            unit_req;
    pcc_pkg::unit_rsp_t            unit_rsp;

    pcc_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    assign in_fire   = req.valid && req.ready;
    assign bad_req   = (req.k_chosen > req.n_total)
                       || (32'(req.n_total) > pcc_pkg::MAX_N);
    assign n_minus_k = req.n_total - req.k_chosen;
    // combination only needs min(k, n-k) steps
    assign steps     = (req.cmd == pcc_pkg::CMD_COMB && n_minus_k < req.k_chosen)
                       ? n_minus_k : req.k_chosen;
    assign i_inc     = i_reg + 1'b1;
    assign too_big   = |unit_rsp.value[pcc_pkg::DQ_W-1:pcc_pkg::COUNT_W];

    assign unit_req.start   = (state_reg == S_ISSUE);
    assign unit_req.use_div = (cmd_reg == pcc_pkg::CMD_COMB);
    assign unit_req.operand = r_reg;
    assign unit_req.factor  = n_reg - i_reg;
    assign unit_req.divisor = i_inc;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        kk_next    = kk_reg;
        r_next     = r_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = req.cmd;
                    n_next   = req.n_total;
                    i_next   = '0;
                    kk_next  = steps;
                    err_next = bad_req;
                    ovf_next = 1'b0;
                    r_next   = bad_req ? '0 : pcc_pkg::COUNT_W'(1);
                    if (bad_req || steps == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (unit_rsp.done)
                begin
                    if (too_big)
                    begin
                        r_next     = pcc_pkg::COUNT_LIMIT;
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next = unit_rsp.value[pcc_pkg::COUNT_W-1:0];
                        i_next = i_inc;
                        state_next = (i_inc == kk_reg) ? S_DONE : S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        n_reg   <= n_next;
        i_reg   <= i_next;
        kk_reg  <= kk_next;
        r_reg   <= r_next;
        err_reg <= err_next;
        ovf_reg <= ovf_next;
        if (out_load)
        begin
            out_count_reg <= r_reg;
            out_err_reg   <= err_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.count       = out_count_reg;
    assign rsp.range_error = out_err_reg;
    assign rsp.overflow    = out_ovf_reg;

    `PCC_ASSERT_NOW(a_start_when_idle, unit_req.start, !unit_rsp.busy)
    `PCC_ASSERT_NEXT(a_busy_after_accept, in_fire, !req.ready)
    `PCC_ASSERT_NOW(a_err_no_ovf, out_valid_reg && out_err_reg,
                    !out_ovf_reg && out_count_reg == '0)
    `PCC_ASSERT_NOW(a_done_only_waiting, unit_rsp.done, state_reg == S_WAIT)

endmodule

@@ design/pcc_unit.sv @@
// Shared multiply and exact-divide unit: a multiply state, then a
// radix-16 restoring division (4 quotient bits per cycle). Depends on pcc_pkg.
module pcc_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::unit_req_t  req,
    output pcc_pkg::unit_rsp_t  rsp
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]                    ustate_reg, ustate_next;
    logic                          done_reg, done_next;
    logic [pcc_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [pcc_pkg::COUNT_W-1:0]   operand_reg;
    logic [pcc_pkg::N_W-1:0]       factor_reg;
    logic [pcc_pkg::N_W-1:0]       divisor_reg;
    logic                          use_div_reg;
    logic [pcc_pkg::DQ_W-1:0]      dq_reg, dq_next;
    logic [pcc_pkg::N_W-1:0]       rem_reg, rem_next;

    logic [pcc_pkg::PROD_W-1:0]    product;
    logic [pcc_pkg::DQ_W-1:0]      dq_dig;
    logic [pcc_pkg::N_W-1:0]       rem_dig;
    logic [pcc_pkg::N_W:0]         rem_try;

    assign product = pcc_pkg::PROD_W'({{pcc_pkg::N_W{1'b0}}, operand_reg}
                     * {{pcc_pkg::COUNT_W{1'b0}}, factor_reg});

    // one radix-16 digit: four shift/compare/subtract steps on a narrow remainder
    always_comb
    begin
        dq_dig  = dq_reg;
        rem_dig = rem_reg;
        rem_try = '0;
        for (int j = 0; j < pcc_pkg::RADIX_BITS; j++)
        begin
            rem_try = {rem_dig, dq_dig[pcc_pkg::DQ_W-1]};
            dq_dig  = {dq_dig[pcc_pkg::DQ_W-2:0], 1'b0};
            if (rem_try >= {1'b0, divisor_reg})
            begin
                rem_try   = rem_try - {1'b0, divisor_reg};
                dq_dig[0] = 1'b1;
            end
            rem_dig = rem_try[pcc_pkg::N_W-1:0];
        end
    end

    always_comb
    begin
        ustate_next = ustate_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        case (ustate_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    ustate_next = U_MUL;
                end
            end
            U_MUL:
            begin
                dq_next   = pcc_pkg::DQ_W'(product);
                rem_next  = '0;
                step_next = '0;
                if (use_div_reg)
                begin
                    ustate_next = U_DIV;
                end
                else
                begin
                    ustate_next = U_IDLE;
                    done_next   = 1'b1;
                end
            end
            U_DIV:
            begin
                dq_next  = dq_dig;
                rem_next = rem_dig;
                if (step_reg == pcc_pkg::STEP_W'(pcc_pkg::DIV_STEPS - 1))
                begin
                    ustate_next = U_IDLE;
                    done_next   = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                ustate_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg <= U_IDLE;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (ustate_reg == U_IDLE && req.start)
        begin
            operand_reg <= req.operand;
            factor_reg  <= req.factor;
            divisor_reg <= req.divisor;
            use_div_reg <= req.use_div;
        end
    end

    assign rsp.busy  = (ustate_reg != U_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.value = dq_reg;

endmodule

@@ tb/permutation_combination_count_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for permutation_combination_count_top.
// Directed table plus random requests with random stalls on both channels;
// depends on pcc_pkg, pcc_if and the RTL of the counter.
module permutation_combination_count_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_SETTLE     = 40;
    localparam int RANDOM_WORDS   = 1100;

    typedef struct packed {
        logic [pcc_pkg::COUNT_W-1:0] count;
        logic                        range_error;
        logic                        overflow;
    } count_result_t;

    typedef struct {
        logic                    cmd;
        logic [pcc_pkg::N_W-1:0] n_total;
        logic [pcc_pkg::N_W-1:0] k_chosen;
        bit                      typed;
        count_result_t           want;
    } stim_row_t;

    localparam count_result_t ONE_WAY   = '{count: 31'd1, range_error: 1'b0, overflow: 1'b0};
    localparam count_result_t RANGE_ERR = '{count: '0, range_error: 1'b1, overflow: 1'b0};
    localparam count_result_t SATURATED =
        '{count: pcc_pkg::COUNT_LIMIT, range_error: 1'b0, overflow: 1'b1};
    localparam count_result_t COUNT_255 =
        '{count: 31'd255, range_error: 1'b0, overflow: 1'b0};
    localparam count_result_t BY_MODEL  = '0;

    // typed rows carry their answer; the rest go through predict_count
    stim_row_t directed_rows [24] = '{
        '{pcc_pkg::CMD_PERM, 8'd0,   8'd0,   1'b1, ONE_WAY},
        '{pcc_pkg::CMD_COMB, 8'd0,   8'd0,   1'b1, ONE_WAY},
        '{pcc_pkg::CMD_PERM, 8'd255, 8'd0,   1'b1, ONE_WAY},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd0,   1'b1, ONE_WAY},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd255, 1'b1, ONE_WAY},
        '{pcc_pkg::CMD_PERM, 8'd1,   8'd1,   1'b1, ONE_WAY},
        '{pcc_pkg::CMD_PERM, 8'd255, 8'd1,   1'b1, COUNT_255},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd1,   1'b1, COUNT_255},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd254, 1'b1, COUNT_255},
        '{pcc_pkg::CMD_PERM, 8'd0,   8'd1,   1'b1, RANGE_ERR},
        '{pcc_pkg::CMD_COMB, 8'd0,   8'd255, 1'b1, RANGE_ERR},
        '{pcc_pkg::CMD_PERM, 8'd254, 8'd255, 1'b1, RANGE_ERR},
        '{pcc_pkg::CMD_COMB, 8'd1,   8'd128, 1'b1, RANGE_ERR},
        '{pcc_pkg::CMD_PERM, 8'd255, 8'd255, 1'b1, SATURATED},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd127, 1'b1, SATURATED},
        '{pcc_pkg::CMD_COMB, 8'd255, 8'd128, 1'b1, SATURATED},
        '{pcc_pkg::CMD_PERM, 8'd12,  8'd12,  1'b0, BY_MODEL},
        '{pcc_pkg::CMD_PERM, 8'd13,  8'd13,  1'b0, BY_MODEL},
        '{pcc_pkg::CMD_COMB, 8'd33,  8'd16,  1'b0, BY_MODEL},
        '{pcc_pkg::CMD_COMB, 8'd34,  8'd17,  1'b0, BY_MODEL},
        '{pcc_pkg::CMD_PERM, 8'd255, 8'd3,   1'b0, BY_MODEL},
        '{pcc_pkg::CMD_PERM, 8'd255, 8'd4,   1'b0, BY_MODEL},
        '{pcc_pkg::CMD_COMB, 8'd85,  8'd5,   1'b0, BY_MODEL},
        '{pcc_pkg::CMD_COMB, 8'd170, 8'd168, 1'b0, BY_MODEL}
    };

    logic clk;
    logic rst_n;

    pcc_req_if req_ch ();
    pcc_rsp_if rsp_ch ();

    permutation_combination_count_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    count_result_t counts_due [$];
    count_result_t head;
    int            fail_count;
    int            idle_cycles;
    int            stall_left;
    bit            no_idle;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic count_result_t predict_count(logic cmd,
                                                    logic [pcc_pkg::N_W-1:0] n,
                                                    logic [pcc_pkg::N_W-1:0] k);
        count_result_t res;
        logic [63:0]   acc;
        int            nn;
        int            kk;
        int            steps;
        res = '0;
        nn  = int'(n);
        kk  = int'(k);
        if (kk > nn || nn > pcc_pkg::MAX_N)
        begin
            res.range_error = 1'b1;
            return res;
        end
        steps = kk;
        if (cmd == pcc_pkg::CMD_COMB && nn - kk < kk)
            steps = nn - kk;
        acc = 64'd1;
        for (int i = 0; i < steps; i++)
        begin
            acc = acc * 64'(nn - i);
            if (cmd == pcc_pkg::CMD_COMB)
                acc = acc / 64'(i + 1);
            // partial values never shrink, so the first one past the limit decides
            if (acc > 64'(pcc_pkg::COUNT_LIMIT))
            begin
                res.count    = pcc_pkg::COUNT_LIMIT;
                res.overflow = 1'b1;
                return res;
            end
        end
        res.count = acc[pcc_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue_request(logic cmd, logic [pcc_pkg::N_W-1:0] n,
                                 logic [pcc_pkg::N_W-1:0] k,
                                 bit typed, count_result_t want);
        count_result_t e;
        int            gap;
        e   = typed ? want : predict_count(cmd, n, k);
        gap = idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= cmd;
        req_ch.n_total  <= n;
        req_ch.k_chosen <= k;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        counts_due.insert(counts_due.size(), e);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic                    cmd;
        logic [pcc_pkg::N_W-1:0] n;
        logic [pcc_pkg::N_W-1:0] k;
        int                      mode;
        cmd  = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            // anything goes, about half range errors
            n = pcc_pkg::N_W'($urandom_range(0, 255));
            k = pcc_pkg::N_W'($urandom_range(0, 255));
        end
        else if (mode < 55)
        begin
            // small sets with n up to 40; larger k can still saturate
            n = pcc_pkg::N_W'($urandom_range(0, 40));
            k = pcc_pkg::N_W'($urandom_range(0, n));
        end
        else if (mode < 75)
        begin
            // large n near either edge of k keeps combinations in range
            n = pcc_pkg::N_W'($urandom_range(0, 255));
            k = pcc_pkg::N_W'($urandom_range(0, 4));
            if ($urandom_range(0, 1) && n >= k)
                k = n - k;
            if (k > n)
                k = n;
        end
        else
        begin
            n = pcc_pkg::N_W'($urandom_range(0, 255));
            k = pcc_pkg::N_W'($urandom_range(0, n));
        end
        issue_request(cmd, n, k, 1'b0, BY_MODEL);
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = pcc_pkg::CMD_PERM;
        req_ch.n_total  = '0;
        req_ch.k_chosen = '0;
        rsp_ch.ready    = 1'b0;
        fail_count      = 0;
        no_idle         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].cmd, directed_rows[i].n_total,
                          directed_rows[i].k_chosen, directed_rows[i].typed,
                          directed_rows[i].want);
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            no_idle = (i >= 500 && i < 700);
            if (i % 250 == 125)
                drain_results();
            random_request();
        end
        no_idle = 1'b0;

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left   <= idle_gap();
            end
        end
        else
            stall_left <= 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (counts_due.size() == 0)
            begin
                $display("%0t: unexpected result word: count %0d, range_error %0b, overflow %0b",
                         $time, rsp_ch.count, rsp_ch.range_error, rsp_ch.overflow);
                fail_count++;
            end
            else
            begin
                head = counts_due.pop_front();
                if (rsp_ch.count !== head.count)
                begin
                    $display("%0t: count mismatch: expected %0d, got %0d",
                             $time, head.count, rsp_ch.count);
                    fail_count++;
                end
                if (rsp_ch.range_error !== head.range_error)
                begin
                    $display("%0t: range_error mismatch: expected %0b, got %0b",
                             $time, head.range_error, rsp_ch.range_error);
                    fail_count++;
                end
                if (rsp_ch.overflow !== head.overflow)
                begin
                    $display("%0t: overflow mismatch: expected %0b, got %0b",
                             $time, head.overflow, rsp_ch.overflow);
                    fail_count++;
                end
            end
        end
    end

    // counts cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, counts_due.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
